// File: src/wsfd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
`default_nettype none

package wsfd_pkg;

   // Configuration register map
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_MAX_FRAME_BYTES = 1'b0;
   localparam logic [31:0] MAX_FRAME_RESET = 32'd65536;

   // Length codes in the second header byte
   localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
   localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

   // Header sizes in bytes
   localparam logic [3:0] HDR_SIZE_BASE  = 4'd2;
   localparam logic [3:0] HDR_SIZE_EXT16 = 4'd4;
   localparam logic [3:0] HDR_SIZE_EXT64 = 4'd10;
   localparam logic [3:0] HDR_SIZE_KEY   = 4'd4;

   // Byte counts of the variable header fields
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] KEY_BYTES   = 4'd4;

   typedef enum logic [5:0] {
      PH_HDR0    = 6'b000001,
      PH_HDR1    = 6'b000010,
      PH_EXT16   = 6'b000100,
      PH_EXT64   = 6'b001000,
      PH_MASK    = 6'b010000,
      PH_PAYLOAD = 6'b100000
   } parse_phase_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_EMPTY = 2'd1,
      KIND_ERROR = 2'd2
   } result_kind_type;

   typedef struct packed {
      logic            valid;
      result_kind_type kind;
      logic [3:0]      opcode;
      logic [7:0]      data;
      logic            last;
   } parse_result_type;

endpackage

`default_nettype wire

// File: src/wsfd_csr.sv
// Configuration register block holding the maximum frame size.
`default_nettype none

module wsfd_csr
   import wsfd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic      [31:0]           prdata,
   output logic                       pready,
   output logic      [31:0]           max_frame_bytes
);

   logic [31:0] max_frame_ff;
   logic [31:0] max_frame_in;
   logic        reg_hit;
   logic        wr_en;

   assign reg_hit = (paddr[CSR_ADDR_W-1] == REG_MAX_FRAME_BYTES);
   assign wr_en   = psel && penable && pwrite && reg_hit;
   assign pready  = 1'b1;

   // Write path
   always_comb begin
      max_frame_in = max_frame_ff;
      if (wr_en) begin
         max_frame_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_ff <= MAX_FRAME_RESET;
      end else begin
         max_frame_ff <= max_frame_in;
      end
   end

   // Read path; unmapped addresses read zero
   assign prdata          = reg_hit ? max_frame_ff : 32'd0;
   assign max_frame_bytes = max_frame_ff;

endmodule

`default_nettype wire

// File: src/wsfd_parser.sv
// Frame header parser, size check and payload unmasking for one byte per clock while fire is high.
`default_nettype none

module wsfd_parser
   import wsfd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       fire,
   input  wire logic [7:0] rx_byte,
   input  wire logic [31:0] max_frame_bytes,
   output parse_result_type result
);

   parse_phase_type phase_ff, phase_in;
   logic [3:0]      hidx_ff, hidx_in;
   logic [3:0]      opcode_ff, opcode_in;
   logic            mask_ff, mask_in;
   logic [63:0]     len_ff, len_in;
   logic [31:0]     key_ff, key_in;
   logic [31:0]     pos_ff, pos_in;
   logic            error_ff, error_in;

   logic [3:0]      hidx_inc;
   logic            fin_go;
   logic [63:0]     fin_len;
   logic [3:0]      fin_hdr;
   logic            fin_mask;
   logic [32:0]     frame_total;
   logic            oversize;
   logic [7:0]      key_byte;
   logic [32:0]     pos_plus;
   logic            pay_last;

   assign hidx_inc = hidx_ff + 4'd1;

   // Length field completion: which byte finishes it and the header size
   always_comb begin
      fin_go   = 1'b0;
      fin_len  = len_ff;
      fin_hdr  = HDR_SIZE_BASE;
      fin_mask = mask_ff;
      case (phase_ff)
         PH_HDR1: begin
            fin_mask = rx_byte[7];
            fin_len  = {57'd0, rx_byte[6:0]};
            fin_go   = (rx_byte[6:0] != LEN_CODE_EXT16) && (rx_byte[6:0] != LEN_CODE_EXT64);
         end
         PH_EXT16: begin
            fin_len = {len_ff[55:0], rx_byte};
            fin_hdr = HDR_SIZE_EXT16;
            fin_go  = (hidx_inc == EXT16_BYTES);
         end
         PH_EXT64: begin
            fin_len = {len_ff[55:0], rx_byte};
            fin_hdr = HDR_SIZE_EXT64;
            fin_go  = (hidx_inc == EXT64_BYTES);
         end
         default: begin
            fin_go = 1'b0;
         end
      endcase
      if (fin_mask) begin
         fin_hdr = fin_hdr + HDR_SIZE_KEY;
      end
   end

   // Size check: any length above 32 bits already exceeds the limit
   assign frame_total = {1'b0, fin_len[31:0]} + {29'd0, fin_hdr};
   assign oversize    = (|fin_len[63:32]) || (frame_total > {1'b0, max_frame_bytes});

   // Key byte for the current payload position
   always_comb begin
      case (pos_ff[1:0])
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   assign pos_plus = {1'b0, pos_ff} + 33'd1;
   assign pay_last = (pos_plus == len_ff[32:0]) && (len_ff[63:33] == '0);

   // Next state and result
   always_comb begin
      phase_in = phase_ff;
      hidx_in  = hidx_ff;
      opcode_in = opcode_ff;
      mask_in  = mask_ff;
      len_in   = len_ff;
      key_in   = key_ff;
      pos_in   = pos_ff;
      error_in = error_ff;

      result.valid  = 1'b0;
      result.kind   = KIND_DATA;
      result.opcode = opcode_ff;
      result.data   = 8'd0;
      result.last   = 1'b0;

      if (!error_ff) begin
         case (phase_ff)
            PH_HDR1: begin
               mask_in = rx_byte[7];
               hidx_in = 4'd0;
               len_in  = {57'd0, rx_byte[6:0]};
               if (rx_byte[6:0] == LEN_CODE_EXT16) begin
                  phase_in = PH_EXT16;
                  len_in   = '0;
               end else if (rx_byte[6:0] == LEN_CODE_EXT64) begin
                  phase_in = PH_EXT64;
                  len_in   = '0;
               end
            end
            PH_EXT16, PH_EXT64: begin
               len_in  = {len_ff[55:0], rx_byte};
               hidx_in = hidx_inc;
            end
            PH_MASK: begin
               key_in  = {key_ff[23:0], rx_byte};
               hidx_in = hidx_inc;
               if (hidx_inc == KEY_BYTES) begin
                  pos_in = 32'd0;
                  if (len_ff == '0) begin
                     phase_in     = PH_HDR0;
                     result.valid = 1'b1;
                     result.kind  = KIND_EMPTY;
                     result.last  = 1'b1;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               result.valid = 1'b1;
               result.kind  = KIND_DATA;
               result.data  = rx_byte ^ (mask_ff ? key_byte : 8'd0);
               result.last  = pay_last;
               pos_in       = pos_plus[31:0];
               if (pay_last) begin
                  phase_in = PH_HDR0;
               end
            end
            default: begin
               // first header byte, also any stray phase code
               opcode_in = rx_byte[3:0];
               phase_in  = PH_HDR1;
            end
         endcase

         // Length complete: error, mask key, empty frame or payload
         if (fin_go) begin
            if (oversize) begin
               error_in     = 1'b1;
               phase_in     = PH_HDR0;
               result.valid = 1'b1;
               result.kind  = KIND_ERROR;
               result.last  = 1'b1;
            end else begin
               hidx_in = 4'd0;
               key_in  = 32'd0;
               if (fin_mask) begin
                  phase_in = PH_MASK;
               end else begin
                  pos_in = 32'd0;
                  if (fin_len == '0) begin
                     phase_in     = PH_HDR0;
                     result.valid = 1'b1;
                     result.kind  = KIND_EMPTY;
                     result.last  = 1'b1;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         hidx_ff   <= 4'd0;
         opcode_ff <= 4'd0;
         mask_ff   <= 1'b0;
         len_ff    <= '0;
         key_ff    <= 32'd0;
         pos_ff    <= 32'd0;
         error_ff  <= 1'b0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         hidx_ff   <= hidx_in;
         opcode_ff <= opcode_in;
         mask_ff   <= mask_in;
         len_ff    <= len_in;
         key_ff    <= key_in;
         pos_ff    <= pos_in;
         error_ff  <= error_in;
      end
   end

endmodule

`default_nettype wire

// File: src/websocket_frame_deframer.sv
// A byte accepted into the input register passes through the parser into the result register.
// Throughput: one byte per clock; the input register advances whenever the
// result register is empty or being taken, so rsp_stall alone throttles it.
// Reset (synchronous, active high) clears the parser to await a first header
// byte, clears the error latch and sets max_frame_bytes to 65536.
`default_nettype none

module websocket_frame_deframer
   import wsfd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_rx_byte,
   // result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [1:0]                 rsp_result_kind,
   output logic [3:0]                 rsp_frame_opcode,
   output logic [7:0]                 rsp_payload_byte,
   output logic                       rsp_frame_last,
   // configuration port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic      [31:0]           csr_prdata,
   output logic                       csr_pready
);

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff, in_byte_in;
   logic             rsp_valid_ff, rsp_valid_in;
   result_kind_type  rsp_kind_ff, rsp_kind_in;
   logic [3:0]       rsp_opcode_ff, rsp_opcode_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             advance;
   logic             req_take;
   logic [31:0]      max_frame_bytes;
   parse_result_type result;

   wsfd_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .psel            (csr_psel),
      .penable         (csr_penable),
      .pwrite          (csr_pwrite),
      .paddr           (csr_paddr),
      .pwdata          (csr_pwdata),
      .prdata          (csr_prdata),
      .pready          (csr_pready),
      .max_frame_bytes (max_frame_bytes)
   );

   // Request moves from the input register into the parser
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   wsfd_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .fire            (advance),
      .rx_byte         (in_byte_ff),
      .max_frame_bytes (max_frame_bytes),
      .result          (result)
   );

   // Input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_opcode_in = rsp_opcode_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      if (advance) begin
         rsp_valid_in = result.valid;
         if (result.valid) begin
            rsp_kind_in   = result.kind;
            rsp_opcode_in = result.opcode;
            rsp_byte_in   = result.data;
            rsp_last_in   = result.last;
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff    <= in_byte_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_opcode_ff <= rsp_opcode_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_frame_opcode = rsp_opcode_ff;
   assign rsp_payload_byte = rsp_byte_ff;
   assign rsp_frame_last   = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // Nothing follows a delivered error result
   a_error_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && (rsp_result_kind == KIND_ERROR)) |=> !rsp_valid)
      else $error("result delivered after frame error");

   // Empty-frame and error results carry a zero byte and the last flag
   a_non_data_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_kind != KIND_DATA)) |-> (rsp_frame_last && (rsp_payload_byte == 8'd0)))
      else $error("non-data result with payload byte or without last flag");

   // A held request stays put while the result side is blocked
   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && rsp_stall) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("input register changed while blocked");
`endif

endmodule

`default_nettype wire
